### hdl/lse_pkg.sv
// Shared constants and types for the LIFO stack engine.
// Used by lifo_stack_engine_core and lse_store; depends on nothing else.
`default_nettype none

package lse_pkg;

    // Port field widths.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;
    localparam int TDATA_W  = VALUE_W + COUNT_W + 2;

    // Action codes carried on s_tuser.
    localparam logic [ACTION_W-1:0] ACT_PUSH     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_TRAVERSE = 3'd4;

    // Status codes carried on m_tuser.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // Port enables from the control logic to the entry memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } lse_mem_ctl_t;

endpackage

`default_nettype wire

### hdl/lifo_stack_engine_core.sv
// LIFO stack engine, top level. Depends on lse_pkg and lse_store.
// Push, clear, refusals and unused actions: one item per cycle if the output is free.
// Pop and peek: the entry read is registered; no input is taken until the result loads.
// Traverse of N entries: N results at one per cycle while the output is free.
// Reset (aresetn low, synchronous) empties the stack; stored entries are not cleared.
`default_nettype none

module lifo_stack_engine_core
    import lse_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // push_value
    input  wire logic [ACTION_W-1:0] s_tuser,   // action
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [TDATA_W-1:0]  m_tdata,   // read_value, count, is_full, is_empty
    output logic      [STATUS_W-1:0] m_tuser,   // status
    output logic                     m_tlast    // last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [CW-1:0]         left_reg, left_next;
    logic                  rd_pend_reg, rd_pend_next;

    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]    out_value_reg, out_value_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [CW-1:0]         out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;

    lse_mem_ctl_t          mem_ctl;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  accept, out_free, is_full, is_empty;
    logic                  load, issue;
    logic                  res_load, res_last;
    logic [VALUE_W-1:0]    res_value;
    logic [STATUS_W-1:0]   res_status;
    logic [CW-1:0]         res_count;

    lse_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (DATA_WIDTH'(s_tdata)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // In the stream state a result is taken from the read register while the
    // next read is issued, so the memory read overlaps the output handshake.
    assign load  = (state_reg == ST_STREAM) && rd_pend_reg && out_free;
    assign issue = (state_reg == ST_STREAM) && (left_reg != '0) && (!rd_pend_reg || load);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        left_next     = left_reg;
        rd_pend_next  = rd_pend_reg;
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        rd_addr       = addr_reg;
        res_load      = 1'b0;
        res_value     = '0;
        res_status    = STAT_OK;
        res_last      = 1'b1;

        if (accept) begin
            res_load = 1'b1;
            case (s_tuser)
                ACT_PUSH: begin
                    if (is_full) begin
                        res_status = STAT_FULL;
                    end else begin
                        mem_ctl.wr_en = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                ACT_POP, ACT_PEEK, ACT_TRAVERSE: begin
                    if (is_empty) begin
                        res_status = STAT_EMPTY;
                    end else begin
                        res_load      = 1'b0;
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(count_reg - 1'b1);
                        addr_next     = AW'(count_reg - 2'd2);
                        rd_pend_next  = 1'b1;
                        state_next    = ST_STREAM;
                        left_next     = (s_tuser == ACT_TRAVERSE) ? count_reg - 1'b1 : '0;
                        if (s_tuser == ACT_POP) begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end

        if (state_reg == ST_STREAM) begin
            if (load) begin
                res_load  = 1'b1;
                res_value = VALUE_W'(rd_data);
                res_last  = (left_reg == '0);
                if (left_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            if (issue) begin
                mem_ctl.rd_en = 1'b1;
                addr_next     = addr_reg - 1'b1;
                left_next     = left_reg - 1'b1;
            end
            rd_pend_next = issue || (rd_pend_reg && !load);
        end

        res_count = count_next;

        m_valid_next    = m_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (res_load) begin
            m_valid_next    = 1'b1;
            out_value_next  = res_value;
            out_status_next = res_status;
            out_count_next  = res_count;
            out_last_next   = res_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg       <= addr_next;
        left_reg       <= left_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_count_reg == '0, out_count_reg == CW'(DEPTH),
                       COUNT_W'(out_count_reg), out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("stack count exceeds depth");

    a_pend_in_stream: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_STREAM)
        else $error("read pending outside stream state");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == ACT_PUSH && !is_full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted push did not grow the stack");

    a_stream_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STREAM) |-> !s_tready)
        else $error("input accepted while a read result is outstanding");

endmodule

`default_nettype wire

### hdl/lse_store.sv
// Entry memory of the LIFO stack engine: one write port, one read port,
// read data registered. Depends on lse_pkg.
`default_nettype none

module lse_store
    import lse_pkg::*;
#(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = 5
) (
    input  wire logic                  aclk,
    input  wire lse_mem_ctl_t          ctl,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds while no read is issued, so a stalled result waits here.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for lifo_stack_engine_core: a directed table, then random sequences
// of all actions, every result checked against a hand-written value or a behavioral stack.
// Depends on lse_pkg and the RTL of lifo_stack_engine_core.
module tb
    import lse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = 32;
    localparam int RANDOM_ITEMS = 310;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int DRAIN_CYCLES = 3 * STACK_DEPTH;

    // Action codes the block does not use; they must come back as a plain OK.
    localparam logic [ACTION_W-1:0] ACT_UNUSED5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_full;
        logic                is_empty;
        logic                last;
    } stack_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        logic                typed;
        stack_result_t       want;
    } stim_row_t;

    localparam int N_DIRECTED = 21;

    // Rows with typed set carry a hand-written result; the others use the stack model.
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{ACT_POP,      32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_PEEK,     32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_EMPTY, 6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_TRAVERSE, 32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_PUSH,     32'h0000_0000, 1'b1, '{32'h0, STAT_OK,    6'd1, 1'b0, 1'b0, 1'b1}},
        '{ACT_PUSH,     32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK,    6'd2, 1'b0, 1'b0, 1'b1}},
        '{ACT_PEEK,     32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, STAT_OK, 6'd2, 1'b0, 1'b0, 1'b1}},
        '{ACT_PUSH,     32'h8000_0001, 1'b0, '0},
        '{ACT_TRAVERSE, 32'hFFFF_FFFF, 1'b0, '0},
        '{ACT_POP,      32'h0000_0000, 1'b1,
          '{32'h8000_0001, STAT_OK, 6'd2, 1'b0, 1'b0, 1'b1}},
        '{ACT_POP,      32'h0000_0000, 1'b1,
          '{32'hFFFF_FFFF, STAT_OK, 6'd1, 1'b0, 1'b0, 1'b1}},
        '{ACT_POP,      32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK,    6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_UNUSED5,  32'hDEAD_BEEF, 1'b1, '{32'h0, STAT_OK,    6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_UNUSED6,  32'hFFFF_FFFF, 1'b1, '{32'h0, STAT_OK,    6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_UNUSED7,  32'h0000_0000, 1'b1, '{32'h0, STAT_OK,    6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_PUSH,     32'h1234_5678, 1'b0, '0},
        '{ACT_UNUSED7,  32'h5555_AAAA, 1'b0, '0},
        '{ACT_PUSH,     32'h5A5A_5A5A, 1'b0, '0},
        '{ACT_CLEAR,    32'hA5A5_A5A5, 1'b1, '{32'h0, STAT_OK,    6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_PEEK,     32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_TRAVERSE, 32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 6'd0, 1'b0, 1'b1, 1'b1}},
        '{ACT_PUSH,     32'h0000_0001, 1'b0, '0}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata;
    logic [ACTION_W-1:0] s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0] m_tuser;
    logic                m_tlast;

    logic [VALUE_W-1:0] stack_words [STACK_DEPTH];
    int                 stack_level;
    stack_result_t      awaited_results [$];
    int                 mismatch_count = 0;
    int                 items_sent     = 0;
    int                 cycle_count    = 0;
    int                 send_burst     = 0;
    int                 take_burst     = 0;

    lifo_stack_engine_core #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (VALUE_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Random wait before an item, with occasional stretches of back-to-back traffic.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(10, 40);
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic void note_result(logic [VALUE_W-1:0] value, logic [STATUS_W-1:0] status,
                                        logic last);
        stack_result_t res;
        res.read_value = value;
        res.status     = status;
        res.count      = stack_level[COUNT_W-1:0];
        res.is_full    = (stack_level == STACK_DEPTH);
        res.is_empty   = (stack_level == 0);
        res.last       = last;
        awaited_results.push_back(res);
    endfunction

    // Applies one accepted item to the stack copy and queues the results it must produce.
    function automatic void stack_apply(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
        int i;
        case (act)
            ACT_PUSH: begin
                if (stack_level == STACK_DEPTH) begin
                    note_result('0, STAT_FULL, 1'b1);
                end else begin
                    stack_words[stack_level] = val;
                    stack_level++;
                    note_result('0, STAT_OK, 1'b1);
                end
            end
            ACT_POP: begin
                if (stack_level == 0) begin
                    note_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    stack_level--;
                    note_result(stack_words[stack_level], STAT_OK, 1'b1);
                end
            end
            ACT_PEEK: begin
                if (stack_level == 0) begin
                    note_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    note_result(stack_words[stack_level-1], STAT_OK, 1'b1);
                end
            end
            ACT_CLEAR: begin
                stack_level = 0;
                note_result('0, STAT_OK, 1'b1);
            end
            ACT_TRAVERSE: begin
                if (stack_level == 0) begin
                    note_result('0, STAT_EMPTY, 1'b1);
                end else begin
                    for (i = stack_level - 1; i >= 0; i--) begin
                        note_result(stack_words[i], STAT_OK, i == 0);
                    end
                end
            end
            default: begin
                note_result('0, STAT_OK, 1'b1);
            end
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                             input logic typed, input stack_result_t want);
        int gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        stack_apply(act, val);
        if (typed) begin
            void'(awaited_results.pop_back());
            awaited_results.push_back(want);
        end
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        int row;
        int kind;
        int n;
        int r;
        logic [ACTION_W-1:0] act;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_PUSH;
        stack_level = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < N_DIRECTED; row++) begin
            send_item(directed_rows[row].action, directed_rows[row].value,
                      directed_rows[row].typed, directed_rows[row].want);
        end

        // The first random episode always fills the stack so the full case is reached early.
        kind = 0;
        while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
            case (kind)
                0: begin
                    while (stack_level < STACK_DEPTH) begin
                        send_item(ACT_PUSH, draw_value(), 1'b0, '0);
                    end
                    send_item(ACT_PUSH, draw_value(), 1'b0, '0);
                    send_item(ACT_PEEK, draw_value(), 1'b0, '0);
                    send_item(ACT_PUSH, draw_value(), 1'b0, '0);
                    send_item(ACT_TRAVERSE, draw_value(), 1'b0, '0);
                    repeat ($urandom_range(0, 5)) send_item(ACT_POP, draw_value(), 1'b0, '0);
                end
                1: begin
                    while (stack_level > 0) begin
                        send_item(ACT_POP, draw_value(), 1'b0, '0);
                    end
                    send_item(ACT_POP, draw_value(), 1'b0, '0);
                    send_item(ACT_PEEK, draw_value(), 1'b0, '0);
                    send_item(ACT_TRAVERSE, draw_value(), 1'b0, '0);
                end
                default: begin
                    for (n = 0; n < 10; n++) begin
                        r = $urandom_range(0, 99);
                        if (r < 40) begin
                            act = ACT_PUSH;
                        end else if (r < 65) begin
                            act = ACT_POP;
                        end else if (r < 75) begin
                            act = ACT_PEEK;
                        end else if (r < 83) begin
                            act = ACT_TRAVERSE;
                        end else if (r < 88) begin
                            act = ACT_CLEAR;
                        end else if (r < 92) begin
                            act = ACTION_W'($urandom_range(ACT_UNUSED5, ACT_UNUSED7));
                        end else begin
                            act = ACT_PUSH;
                        end
                        send_item(act, draw_value(), 1'b0, '0);
                    end
                end
            endcase
            kind = $urandom_range(0, 9);
        end
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("lifo_stack_engine_core test passed");
        end else begin
            $display("lifo_stack_engine_core test failed");
        end
        $finish;
    end

    // Result side: random back-pressure before each item, then hold ready until it is taken.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = draw_gap(take_burst);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        stack_result_t got;
        stack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.read_value = m_tdata[VALUE_W-1:0];
            got.status     = m_tuser;
            got.count      = m_tdata[VALUE_W +: COUNT_W];
            got.is_full    = m_tdata[VALUE_W + COUNT_W];
            got.is_empty   = m_tdata[VALUE_W + COUNT_W + 1];
            got.last       = m_tlast;
            if (awaited_results.size() == 0) begin
                $error("result item with none expected: tdata 0x%0h tuser %0d tlast %0b",
                       m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("read_value", want.read_value, got.read_value);
                check_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
                check_field("count", VALUE_W'(want.count), VALUE_W'(got.count));
                check_field("is_full", VALUE_W'(want.is_full), VALUE_W'(got.is_full));
                check_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
                check_field("last", VALUE_W'(want.last), VALUE_W'(got.last));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("lifo_stack_engine_core test failed");
        $finish;
    end

endmodule
